>>> sv/uite_pkg.sv
// Shared types, field codes and bit masks for the UART interrupt transfer engine.
// No dependencies; every other file imports this package.
package uite_pkg;

	localparam int LENGTH_WIDTH = 16;
	localparam int IDX_W = 16;
	localparam int CB_W = 7;

	typedef enum logic [1:0] {
		OP_EVENT    = 2'd0,
		OP_START_RX = 2'd1,
		OP_START_TX = 2'd2,
		OP_UNUSED   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_STORE  = 3'd1,
		ACT_SEND   = 3'd2,
		ACT_TXFIN  = 3'd3,
		ACT_REFUSE = 3'd4,
		ACT_ERROR  = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		ERR_OK        = 3'd0,
		ERR_PARITY    = 3'd1,
		ERR_FRAMING   = 3'd2,
		ERR_NOISE     = 3'd3,
		ERR_OVERRUN   = 3'd4,
		ERR_NOT_READY = 3'd5
	} err_t;

	// status flag bit positions
	localparam int SF_PARITY  = 0;
	localparam int SF_FRAMING = 1;
	localparam int SF_NOISE   = 2;
	localparam int SF_OVERRUN = 3;
	localparam int SF_RXNE    = 5;
	localparam int SF_TC      = 6;
	localparam int SF_TXE     = 7;

	// control bit positions
	localparam int CB_RX_EN = 0;
	localparam int CB_TX_EN = 1;

	// rx en, idle ie, rxne ie, pe ie
	localparam logic [CB_W-1:0] RX_CTRL_MASK = 7'b100_1101;
	// tx en, idle ie, tc ie, txe ie, pe ie
	localparam logic [CB_W-1:0] TX_CTRL_MASK = 7'b111_0110;

	typedef struct packed {
		opcode_t                   opcode;
		logic [7:0]                status_flags;
		logic [7:0]                rx_byte;
		logic [7:0]                tx_byte;
		logic [15:0]               transfer_length;
	} item_t;

	typedef struct packed {
		logic [LENGTH_WIDTH-1:0] rx_remaining;
		logic [LENGTH_WIDTH-1:0] rx_position;
		logic [LENGTH_WIDTH-1:0] tx_remaining;
		logic [LENGTH_WIDTH-1:0] tx_position;
		logic                    rx_finished;
		logic                    tx_finished;
		logic [CB_W-1:0]         enable_bits;
		err_t                    last_error;
	} state_t;

	typedef struct packed {
		action_t          action;
		logic [7:0]       data_byte;
		logic [IDX_W-1:0] buffer_index;
		logic [IDX_W-1:0] next_tx_index;
		err_t             error_code;
		logic             read_done;
		logic             write_done;
		logic [CB_W-1:0]  control_bits;
	} result_t;

endpackage

>>> sv/uite_step.sv
// Per-item decode: start commands and prioritized status event handling.
// Depends on uite_pkg.
module uite_step import uite_pkg::*; (
	input  state_t  state,
	input  item_t   item,
	output state_t  state_next,
	output result_t result
);

	logic [LENGTH_WIDTH-1:0] len;
	logic [LENGTH_WIDTH-1:0] rx_rem_dec;
	logic [LENGTH_WIDTH-1:0] idx;
	action_t                 action;
	logic [7:0]              data;
	state_t                  nxt;

	assign len = LENGTH_WIDTH'(item.transfer_length);
	assign rx_rem_dec = state.rx_remaining - LENGTH_WIDTH'(1);

	always_comb begin
		nxt = state;
		action = ACT_NONE;
		data = '0;
		idx = '0;
		unique case (item.opcode)
			OP_START_RX: begin
				if (state.enable_bits[CB_RX_EN] || len == '0) begin
					action = ACT_REFUSE;
					nxt.last_error = ERR_NOT_READY;
				end else begin
					nxt.rx_finished = 1'b0;
					nxt.rx_position = '0;
					nxt.rx_remaining = len;
					nxt.enable_bits = state.enable_bits | RX_CTRL_MASK;
				end
			end
			OP_START_TX: begin
				if (state.enable_bits[CB_TX_EN] || len == '0) begin
					action = ACT_REFUSE;
					nxt.last_error = ERR_NOT_READY;
				end else begin
					nxt.tx_finished = 1'b0;
					nxt.enable_bits = state.enable_bits | TX_CTRL_MASK;
					action = ACT_SEND;
					data = item.tx_byte;
					nxt.tx_position = LENGTH_WIDTH'(1);
					nxt.tx_remaining = len - LENGTH_WIDTH'(1);
				end
			end
			OP_EVENT: begin
				if (item.status_flags[SF_PARITY]) begin
					nxt.last_error = ERR_PARITY;
					action = ACT_ERROR;
				end else if (item.status_flags[SF_FRAMING]) begin
					nxt.last_error = ERR_FRAMING;
					action = ACT_ERROR;
				end else if (item.status_flags[SF_NOISE]) begin
					nxt.last_error = ERR_NOISE;
					action = ACT_ERROR;
				end else if (item.status_flags[SF_OVERRUN]) begin
					nxt.last_error = ERR_OVERRUN;
					action = ACT_ERROR;
				end else if (item.status_flags[SF_RXNE] && state.rx_remaining != '0) begin
					action = ACT_STORE;
					data = item.rx_byte;
					idx = state.rx_position;
					nxt.rx_remaining = rx_rem_dec;
					if (rx_rem_dec == '0) begin
						nxt.enable_bits = state.enable_bits & ~RX_CTRL_MASK;
						nxt.rx_finished = 1'b1;
					end else begin
						nxt.rx_position = state.rx_position + LENGTH_WIDTH'(1);
					end
				end else if (item.status_flags[SF_TXE] && state.tx_remaining != '0) begin
					action = ACT_SEND;
					data = item.tx_byte;
					idx = state.tx_position;
					nxt.tx_position = state.tx_position + LENGTH_WIDTH'(1);
					nxt.tx_remaining = state.tx_remaining - LENGTH_WIDTH'(1);
				end else if (item.status_flags[SF_TC]) begin
					nxt.enable_bits = state.enable_bits & ~TX_CTRL_MASK;
					nxt.tx_finished = 1'b1;
					action = ACT_TXFIN;
				end
			end
			default: begin
				action = ACT_NONE;
			end
		endcase
	end

	assign state_next = nxt;

	assign result.action        = action;
	assign result.data_byte     = data;
	assign result.buffer_index  = IDX_W'(idx);
	assign result.next_tx_index = IDX_W'(nxt.tx_position);
	assign result.error_code    = nxt.last_error;
	assign result.read_done     = nxt.rx_finished;
	assign result.write_done    = nxt.tx_finished;
	assign result.control_bits  = nxt.enable_bits;

endmodule

>>> sv/uart_irq_transfer_engine_top.sv
// Top level of the UART interrupt transfer engine: input register, transfer state,
// result register. Depends on uite_pkg and uite_step.
//
// channel  dir  handshake                 payload
// s_*      in   s_tvalid / s_tready       s_tuser opcode, s_tdata flags/bytes/length
// m_*      out  m_tvalid / m_tready       m_tuser action, m_tdata result fields
//
// One item per cycle unless the result stalls; each goes via input and result register.
// The transfer state updates as an item moves from the input register to the result
// register, so each item sees the state left by the one before it.
// Reset clears the counters and enables and sets both finished flags.
// A stalled result holds; one more item waits in the input register behind it.
module uart_irq_transfer_engine_top import uite_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // status_flags, rx_byte, tx_byte, transfer_length
	input  logic [1:0]  s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // data_byte, buffer_index, next_tx_index, error_code,
	                              // read_done, write_done, control_bits, zero pad
	output logic [2:0]  m_tuser   // action
);

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t result_q;
	state_t  state_q;
	state_t  state_next;
	result_t result;
	logic    advance;
	logic    fire;
	logic    s_accept;

	assign advance  = !out_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	uite_step u_step (
		.state      (state_q),
		.item       (item_s1),
		.state_next (state_next),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1.opcode          <= opcode_t'(s_tuser);
			item_s1.status_flags    <= s_tdata[7:0];
			item_s1.rx_byte         <= s_tdata[15:8];
			item_s1.tx_byte         <= s_tdata[23:16];
			item_s1.transfer_length <= s_tdata[39:24];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.rx_remaining <= '0;
			state_q.rx_position  <= '0;
			state_q.tx_remaining <= '0;
			state_q.tx_position  <= '0;
			state_q.rx_finished  <= 1'b1;
			state_q.tx_finished  <= 1'b1;
			state_q.enable_bits  <= '0;
			state_q.last_error   <= ERR_OK;
		end else if (fire) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = result_q.action;
	assign m_tdata  = {4'b0000,
		result_q.control_bits,
		result_q.write_done,
		result_q.read_done,
		result_q.error_code,
		result_q.next_tx_index,
		result_q.buffer_index,
		result_q.data_byte};

	a_rx_fin_en: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.rx_finished == !state_q.enable_bits[CB_RX_EN])
		else $error("rx finished flag disagrees with rx enable");

	a_tx_fin_en: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.tx_finished == !state_q.enable_bits[CB_TX_EN])
		else $error("tx finished flag disagrees with tx enable");

	a_rx_en_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.enable_bits[CB_RX_EN] |-> state_q.rx_remaining != '0)
		else $error("rx enabled with no bytes left");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input taken while both stages are held");

endmodule
